### rtl/impt_pkg.sv
package impt_pkg;

   localparam int KEY_W   = 32;
   localparam int LEVEL_W = 16;
   localparam int ORDER_W = 32;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 3;

   localparam logic [OP_W-1:0] OP_ARRIVE = 2'd0;
   localparam logic [OP_W-1:0] OP_RAISE  = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY     = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_DUPLICATE = 3'd4;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0] level;
      logic [ORDER_W-1:0] order;
   } entry_type;

endpackage

### rtl/indexed_max_priority_table_top.sv
// Keyed priority table of CAPACITY entries. Each request word carries an
// operation (arrive, raise level, remove, query highest), a 32-bit key and a
// 16-bit amount, and produces exactly one response word with a status and,
// for a successful query, the key of the entry with the highest level (the
// earliest arrival wins among equal levels). All entries live in one
// synchronous memory with one read port and one write port; every operation
// reads the whole table through that memory, one entry per cycle. A word is
// accepted in idle, the table is streamed in scan, and in done the write-back
// happens and the response register is loaded; the next word is accepted
// only after that. After reset the block clears the valid bits of every slot
// in the memory before it accepts the first word. A request can be accepted
// while the previous response still waits on rsp_ready; the new result is
// only written to the response register once that one has been taken.
module indexed_max_priority_table_top #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [impt_pkg::OP_W-1:0]     req_operation,
   input  logic [impt_pkg::KEY_W-1:0]    req_item_key,
   input  logic [impt_pkg::LEVEL_W-1:0]  req_amount,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [impt_pkg::STAT_W-1:0]   rsp_status,
   output logic [impt_pkg::KEY_W-1:0]    rsp_top_key
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   // controller states
   localparam logic [1:0] ST_CLEAR = 2'd0;   // post-reset valid-bit sweep
   localparam logic [1:0] ST_IDLE  = 2'd1;   // ready for a request word
   localparam logic [1:0] ST_SCAN  = 2'd2;   // stream table through the read port
   localparam logic [1:0] ST_DONE  = 2'd3;   // write back, load response

   logic [1:0] state_ff, state_in;

   // entry memory: one write and one registered read per cycle
   impt_pkg::entry_type mem [CAPACITY];
   impt_pkg::entry_type rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   impt_pkg::entry_type wr_data;

   // scan sequencing
   logic [IDX_W-1:0] issue_idx_ff, issue_idx_in;
   logic             issuing_ff, issuing_in;
   logic             data_valid_ff, data_valid_in;
   logic [IDX_W-1:0] data_idx_ff, data_idx_in;

   // latched request word
   logic [impt_pkg::OP_W-1:0]    op_ff;
   logic [impt_pkg::KEY_W-1:0]   key_ff;
   logic [impt_pkg::LEVEL_W-1:0] amt_ff;

   // scan results
   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              found_idx_ff, found_idx_in;
   logic [impt_pkg::LEVEL_W-1:0]  found_level_ff, found_level_in;
   logic [impt_pkg::ORDER_W-1:0]  found_order_ff, found_order_in;
   logic                          free_ff, free_in;
   logic [IDX_W-1:0]              free_idx_ff, free_idx_in;
   logic                          best_ff, best_in;
   logic [impt_pkg::LEVEL_W-1:0]  best_level_ff, best_level_in;
   logic [impt_pkg::ORDER_W-1:0]  best_order_ff, best_order_in;
   logic [impt_pkg::KEY_W-1:0]    best_key_ff, best_key_in;

   logic [impt_pkg::ORDER_W-1:0]  arrival_ff, arrival_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [impt_pkg::STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [impt_pkg::KEY_W-1:0]    rsp_top_key_ff, rsp_top_key_in;

   logic                          req_take;
   logic                          done_fire;
   logic [impt_pkg::LEVEL_W:0]    raise_sum;
   logic [impt_pkg::LEVEL_W-1:0]  raise_level;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_take    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_top_key = rsp_top_key_ff;

   // the response register must be free before a result is loaded
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign rd_addr = issue_idx_ff;

   // saturating raise
   assign raise_sum   = {1'b0, found_level_ff} + {1'b0, amt_ff};
   assign raise_level = raise_sum[impt_pkg::LEVEL_W] ? impt_pkg::LEVEL_MAX
                                                     : raise_sum[impt_pkg::LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // sequencer and scan accumulation
   always_comb begin
      state_in       = state_ff;
      issue_idx_in   = issue_idx_ff;
      issuing_in     = issuing_ff;
      data_valid_in  = 1'b0;
      data_idx_in    = data_idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_level_in = found_level_ff;
      found_order_in = found_order_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      best_in        = best_ff;
      best_level_in  = best_level_ff;
      best_order_in  = best_order_ff;
      best_key_in    = best_key_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (issue_idx_ff == LAST_IDX) begin
               issue_idx_in = '0;
               state_in     = ST_IDLE;
            end else begin
               issue_idx_in = issue_idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in     = ST_SCAN;
               issue_idx_in = '0;
               issuing_in   = 1'b1;
               found_in     = 1'b0;
               free_in      = 1'b0;
               best_in      = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               data_valid_in = 1'b1;
               data_idx_in   = issue_idx_ff;
               if (issue_idx_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
            if (data_valid_ff) begin
               if (rd_data_ff.valid) begin
                  // lowest slot holding the key
                  if (!found_ff && rd_data_ff.key == key_ff) begin
                     found_in       = 1'b1;
                     found_idx_in   = data_idx_ff;
                     found_level_in = rd_data_ff.level;
                     found_order_in = rd_data_ff.order;
                  end
                  // highest level, earliest sequence number on a tie
                  if (!best_ff || rd_data_ff.level > best_level_ff ||
                      (rd_data_ff.level == best_level_ff &&
                       rd_data_ff.order < best_order_ff)) begin
                     best_in       = 1'b1;
                     best_level_in = rd_data_ff.level;
                     best_order_in = rd_data_ff.order;
                     best_key_in   = rd_data_ff.key;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = data_idx_ff;
               end
               if (data_idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in     = ST_IDLE;
               issue_idx_in = '0;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // write-back and response
   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = found_idx_ff;
      wr_data        = '{valid: 1'b1, key: key_ff, level: found_level_ff,
                         order: found_order_ff};
      arrival_in     = arrival_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_top_key_in = rsp_top_key_ff;

      if (state_ff == ST_CLEAR) begin
         wr_en         = 1'b1;
         wr_addr       = issue_idx_ff;
         wr_data.valid = 1'b0;
      end

      if (done_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = impt_pkg::STATUS_OK;
         rsp_top_key_in = '0;
         case (op_ff)
            impt_pkg::OP_ARRIVE: begin
               if (found_ff) begin
                  rsp_status_in = impt_pkg::STATUS_DUPLICATE;
               end else if (!free_ff) begin
                  rsp_status_in = impt_pkg::STATUS_FULL;
               end else begin
                  wr_en      = 1'b1;
                  wr_addr    = free_idx_ff;
                  wr_data    = '{valid: 1'b1, key: key_ff, level: amt_ff,
                                 order: arrival_ff};
                  arrival_in = arrival_ff + 1'b1;
               end
            end
            impt_pkg::OP_RAISE: begin
               if (!found_ff) begin
                  rsp_status_in = impt_pkg::STATUS_NOT_FOUND;
               end else begin
                  wr_en         = 1'b1;
                  wr_data.level = raise_level;
               end
            end
            impt_pkg::OP_REMOVE: begin
               if (!found_ff) begin
                  rsp_status_in = impt_pkg::STATUS_NOT_FOUND;
               end else begin
                  wr_en         = 1'b1;
                  wr_data.valid = 1'b0;
               end
            end
            impt_pkg::OP_QUERY: begin
               if (!best_ff) begin
                  rsp_status_in = impt_pkg::STATUS_EMPTY;
               end else begin
                  rsp_top_key_in = best_key_ff;
               end
            end
            default: begin
               rsp_status_in = impt_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         issue_idx_ff  <= '0;
         issuing_ff    <= 1'b0;
         data_valid_ff <= 1'b0;
         arrival_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_idx_ff  <= issue_idx_in;
         issuing_ff    <= issuing_in;
         data_valid_ff <= data_valid_in;
         arrival_ff    <= arrival_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_operation;
         key_ff <= req_item_key;
         amt_ff <= req_amount;
      end
      data_idx_ff    <= data_idx_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      found_level_ff <= found_level_in;
      found_order_ff <= found_order_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      best_ff        <= best_in;
      best_level_ff  <= best_level_in;
      best_order_ff  <= best_order_in;
      best_key_ff    <= best_key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_top_key_ff <= rsp_top_key_in;
   end

   // read pipeline must be drained before write-back
   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> !data_valid_ff && !issuing_ff)
      else $error("write-back with a table read still in flight");

   // an accepted word starts a scan at slot zero
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_SCAN && issuing_ff && issue_idx_ff == '0)
      else $error("scan did not start at slot zero");

   // sequence number steps by at most one per word
   a_arrival_step: assert property (@(posedge clock) disable iff (reset)
      ##1 (arrival_ff == $past(arrival_ff) ||
           arrival_ff == $past(arrival_ff) + 32'd1))
      else $error("arrival counter jumped");

   // a response only appears out of write-back
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside write-back");

   // no write to the table while a scan is reading it
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !wr_en)
      else $error("table written during scan");

endmodule
